### design/amgs_pkg.sv
package amgs_pkg;

	// Entry value that marks a missing edge.
	localparam logic [15:0] NO_EDGE = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_NEIGH  = 3'd1,
		ACT_WEIGHT = 3'd2,
		ACT_CHECK  = 3'd3,
		ACT_VCHECK = 3'd4,
		ACT_LIST   = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		KIND_VERTEX = 3'd0,
		KIND_WEIGHT = 3'd1,
		KIND_YES    = 3'd2,
		KIND_NO     = 3'd3,
		KIND_NOEDGE = 3'd4,
		KIND_EMPTY  = 3'd5,
		KIND_ERROR  = 3'd6
	} kind_t;

endpackage

### design/adjacency_matrix_graph_store.sv
// Weighted directed graph store. The graph lives in one synchronous memory of
// MAX_VERTICES x MAX_VERTICES signed 16-bit weights, where the value -1 means
// that there is no edge. After reset the block first sweeps the memory and
// writes -1 into every entry, one entry per cycle, and in_stall stays high
// until that sweep ends; configuration writes are taken during that sweep.
// Once running, items are served one at a time; a weight query or edge check
// first reads the memory into a read register and then forms its result. The
// neighbour scan reads the row and then the column of the queried vertex
// through the single read port of the matrix memory, one entry per cycle
// while a found index is not held up by a stalled output. Each result item
// leaves through an output register, and the final result item of an input
// item has last set.
module adjacency_matrix_graph_store
	import amgs_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [7:0]         src_vertex,
	input  logic [7:0]         dst_vertex,
	input  logic signed [15:0] edge_weight,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [3:0]         vertex_index,
	output logic signed [15:0] weight,
	output logic               last
);

	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_VERTICES);
	// Count width: holds every value from zero up to MAX_VERTICES.
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int WW    = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_ONE,
		S_LIST,
		S_SCAN
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [4:0]        vertex_count_q;
	logic [IW-1:0]     u_q;
	logic              is_weight_q;
	kind_t             pend_kind_q;
	logic [15:0]       pend_w_q;
	logic [CW-1:0]     j_q;
	logic              col_q;
	logic              hold_v_q;
	logic [IW-1:0]     hold_idx_q;
	logic [CW-1:0]     li_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [3:0]        idx_q;
	logic [15:0]       weight_q;
	logic              last_q;

	// Matrix memory and its read pipeline stage.
	logic [15:0]       mem [DEPTH];
	logic [15:0]       rd_data_s1;
	logic              rd_pend_s1;
	logic [IW-1:0]     tag_s1;

	logic              accept;
	logic [CW-1:0]     n_eff;
	logic [WW-1:0]     vc_ext;
	logic              u_ok;
	logic              v_ok;
	logic [IW-1:0]     u_in;
	logic [IW-1:0]     v_in;
	logic              set_s1;
	logic              out_free;
	logic              scan_done;
	logic              consume;
	logic              issue;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [15:0]       wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	logic              out_load;
	kind_t             out_kind_d;
	logic [3:0]        out_idx_d;
	logic [15:0]       out_w_d;
	logic              out_last_d;

	function automatic logic [AW-1:0] addr_of(logic [IW-1:0] r, logic [IW-1:0] c);
		addr_of = AW'(r * MAX_VERTICES) + AW'(c);
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;

	// A count above the matrix size saturates to the matrix size.
	assign vc_ext = WW'(vertex_count_q);
	assign n_eff  = (vc_ext > WW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_ext);

	assign u_ok = src_vertex < 8'(n_eff);
	assign v_ok = dst_vertex < 8'(n_eff);
	assign u_in = src_vertex[IW-1:0];
	assign v_in = dst_vertex[IW-1:0];

	assign set_s1   = (rd_data_s1 != NO_EDGE);
	assign out_free = !out_valid_q || !out_stall;

	// The scan walks the row first and then the column. One found index is
	// held back so that the final one can be marked last when the walk ends.
	assign scan_done = col_q && (j_q == n_eff);
	assign consume   = rd_pend_s1 && (!set_s1 || !hold_v_q || out_free);
	assign issue     = (state_q == S_SCAN) && !scan_done && (!rd_pend_s1 || consume);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = NO_EDGE;
		rd_en   = 1'b0;
		rd_addr = addr_of(u_in, v_in);
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				if (accept && u_ok && v_ok) begin
					case (action_t'(action))
						ACT_INSERT: begin
							wr_en   = 1'b1;
							wr_addr = addr_of(u_in, v_in);
							wr_data = edge_weight;
						end
						ACT_WEIGHT, ACT_CHECK: begin
							rd_en = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				rd_en   = issue;
				rd_addr = col_q ? addr_of(j_q[IW-1:0], u_q) : addr_of(u_q, j_q[IW-1:0]);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		out_load   = 1'b0;
		out_kind_d = KIND_VERTEX;
		out_idx_d  = 4'd0;
		out_w_d    = 16'd0;
		out_last_d = 1'b0;
		case (state_q)
			S_ONE: begin
				out_load   = out_free;
				out_kind_d = pend_kind_q;
				out_w_d    = pend_w_q;
				out_last_d = 1'b1;
			end
			S_LIST: begin
				out_load   = out_free;
				out_idx_d  = 4'(li_q);
				out_last_d = (li_q == n_eff - CW'(1));
			end
			S_SCAN: begin
				if (consume && set_s1 && hold_v_q) begin
					out_load  = 1'b1;
					out_idx_d = 4'(hold_idx_q);
				end else if (scan_done && !rd_pend_s1) begin
					out_load   = out_free;
					out_kind_d = hold_v_q ? KIND_VERTEX : KIND_EMPTY;
					out_idx_d  = hold_v_q ? 4'(hold_idx_q) : 4'd0;
					out_last_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			tag_s1     <= j_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			vertex_count_q <= 5'd16;
			rd_pend_s1     <= 1'b0;
			hold_v_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vertex_count_q <= cfg_data;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				kind_q      <= out_kind_d;
				idx_q       <= out_idx_d;
				weight_q    <= out_w_d;
				last_q      <= out_last_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						pend_w_q <= 16'd0;
						case (action_t'(action))
							ACT_INSERT: begin
								if (!(u_ok && v_ok)) begin
									pend_kind_q <= KIND_ERROR;
									state_q     <= S_ONE;
								end
							end
							ACT_NEIGH: begin
								if (u_ok) begin
									u_q      <= u_in;
									j_q      <= '0;
									col_q    <= 1'b0;
									hold_v_q <= 1'b0;
									state_q  <= S_SCAN;
								end else begin
									pend_kind_q <= KIND_ERROR;
									state_q     <= S_ONE;
								end
							end
							ACT_WEIGHT, ACT_CHECK: begin
								is_weight_q <= (action_t'(action) == ACT_WEIGHT);
								if (u_ok && v_ok) begin
									state_q <= S_LOOK;
								end else begin
									pend_kind_q <= KIND_ERROR;
									state_q     <= S_ONE;
								end
							end
							ACT_VCHECK: begin
								pend_kind_q <= u_ok ? KIND_YES : KIND_NO;
								state_q     <= S_ONE;
							end
							ACT_LIST: begin
								li_q <= '0;
								if (n_eff == '0) begin
									pend_kind_q <= KIND_EMPTY;
									state_q     <= S_ONE;
								end else begin
									state_q <= S_LIST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LOOK: begin
					if (is_weight_q) begin
						pend_kind_q <= set_s1 ? KIND_WEIGHT : KIND_NOEDGE;
						pend_w_q    <= set_s1 ? rd_data_s1 : 16'd0;
					end else begin
						pend_kind_q <= set_s1 ? KIND_YES : KIND_NO;
					end
					state_q <= S_ONE;
				end
				S_ONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (out_free) begin
						li_q <= li_q + CW'(1);
						if (out_last_d) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_pend_s1 <= 1'b1;
						if (!col_q && (j_q + CW'(1) == n_eff)) begin
							col_q <= 1'b1;
							j_q   <= '0;
						end else begin
							j_q <= j_q + CW'(1);
						end
					end else if (consume) begin
						rd_pend_s1 <= 1'b0;
					end
					if (consume && set_s1) begin
						hold_v_q   <= 1'b1;
						hold_idx_q <= tag_s1;
					end
					if (scan_done && !rd_pend_s1 && out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign vertex_index = idx_q;
	assign weight       = weight_q;
	assign last         = last_q;

	// A result is never loaded over one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten while stalled");

	// The final result of an item always returns the sequencer to idle.
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (state_q == S_IDLE))
		else $error("sequencer busy after final result");

	// The matrix is only written by the clearing sweep or an insert.
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("matrix written outside clearing or insert");

	// Scan read data and the held index never outlive the scan.
	a_scan_scope: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 || hold_v_q) |-> (state_q == S_SCAN))
		else $error("scan state left behind after scan");

endmodule
